@@ sv/rci_pkg.sv @@
// Shared widths, types and helpers for the ray-circle intersection pipeline.
package rci_pkg;

  // Field widths of the channels.
  localparam int CRD_W = 32;   // Q16.16 coordinate
  localparam int DIR_W = 16;   // Q1.15 direction
  localparam int R_W   = 31;   // Q15.16 radius, unsigned
  localparam int DST_W = 32;   // Q16.16 distance, unsigned
  localparam int NRM_W = 16;   // Q1.15 normal

  // Internal widths.
  localparam int OC_W  = CRD_W + 2;          // center + offset - origin
  localparam int PR_W  = OC_W + DIR_W;       // direction times offset vector
  localparam int PS_W  = PR_W + 1;           // sum of two products
  localparam int FRAC_SH = DIR_W - 1;        // drop the Q1.15 scaling
  localparam int PJ_W  = PS_W - FRAC_SH;     // projection and perpendicular
  localparam int T_W   = PJ_W + 1;           // distances along the ray
  localparam int TP_W  = T_W + DIR_W;        // direction times distance
  localparam int V_W   = TP_W + 1;           // normal vector before scaling
  localparam int M_W   = V_W - 1;            // its magnitude
  localparam int N_W   = 30;                 // normalized magnitude
  localparam int SH_W  = 5;                  // normalizing shift count
  localparam int SH_N  = M_W - N_W;          // possible shift positions

  // Square root unit: one result bit per stage.
  localparam int SQ_IN_W  = 2 * R_W;
  localparam int SQ_OUT_W = R_W;
  localparam int SQ_LAT   = SQ_OUT_W;

  // Divider: one quotient bit per stage.
  localparam int DQ_W    = NRM_W - 1;
  localparam int DIV_LAT = DQ_W;
  localparam int REM_W   = SQ_OUT_W + 1;

  localparam int RND_HALF = 1 << (FRAC_SH - 1);
  localparam logic signed [NRM_W-1:0] NRM_MAX = NRM_W'((1 << (NRM_W - 1)) - 1);

  // Per-item data carried beside the first square root.
  typedef struct packed {
    logic                   miss;
    logic signed [PJ_W-1:0] proj;
    logic signed [OC_W-1:0] ocx;
    logic signed [OC_W-1:0] ocy;
    logic signed [DIR_W-1:0] dx;
    logic signed [DIR_W-1:0] dy;
  } side1_t;

  // Hit flag and distances, settled before the normals are worked out.
  typedef struct packed {
    logic             hit;
    logic             ent_zero;
    logic [DST_W-1:0] ent_d;
    logic [DST_W-1:0] ext_d;
  } res_t;

  // Carried beside the second square root (index 0 entry, 1 exit).
  typedef struct packed {
    res_t               res;
    logic [1:0]         sx;
    logic [1:0]         sy;
    logic [1:0]         zr;
    logic [1:0][N_W-1:0] nx;
    logic [1:0][N_W-1:0] ny;
  } sidea_t;

  // Carried beside the dividers.
  typedef struct packed {
    res_t       res;
    logic [1:0] sx;
    logic [1:0] sy;
    logic [1:0] zr;
  } sideb_t;

  // Saturate a distance to the output width, clamping negative values to zero.
  function automatic logic [DST_W-1:0] sat_dist(logic signed [T_W-1:0] t);
    logic [DST_W-1:0] res;
    if (t[T_W-1]) begin
      res = '0;
    end else if (|t[T_W-2:DST_W]) begin
      res = '1;
    end else begin
      res = t[DST_W-1:0];
    end
    return res;
  endfunction

  // Build one signed normal component from the divider result.
  function automatic logic signed [NRM_W-1:0] nrm_fix(logic [DQ_W-1:0] q, logic sat,
                                                      logic neg, logic zero);
    logic signed [NRM_W-1:0] m;
    m = sat ? NRM_MAX : $signed({1'b0, q});
    if (zero) begin
      m = '0;
    end else if (neg) begin
      m = -m;
    end
    return m;
  endfunction

endpackage

@@ sv/rci_ifs.sv @@
// Valid/ready channel interfaces for rays in and intersection results out.
interface rci_in_if import rci_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [CRD_W-1:0] origin_x;
  logic signed [CRD_W-1:0] origin_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic signed [CRD_W-1:0] center_x;
  logic signed [CRD_W-1:0] center_y;
  logic [R_W-1:0]          circle_radius;
  logic signed [CRD_W-1:0] offset_x;
  logic signed [CRD_W-1:0] offset_y;

  modport source (output valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
                  circle_radius, offset_x, offset_y, input ready);
  modport sink (input valid, origin_x, origin_y, dir_x, dir_y, center_x, center_y,
                circle_radius, offset_x, offset_y, output ready);
endinterface

interface rci_out_if import rci_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    hit;
  logic [DST_W-1:0]        enter_distance;
  logic [DST_W-1:0]        exit_distance;
  logic signed [NRM_W-1:0] enter_normal_x;
  logic signed [NRM_W-1:0] enter_normal_y;
  logic signed [NRM_W-1:0] exit_normal_x;
  logic signed [NRM_W-1:0] exit_normal_y;

  modport source (output valid, hit, enter_distance, exit_distance, enter_normal_x,
                  enter_normal_y, exit_normal_x, exit_normal_y, input ready);
  modport sink (input valid, hit, enter_distance, exit_distance, enter_normal_x,
                enter_normal_y, exit_normal_x, exit_normal_y, output ready);
endinterface

@@ sv/rci_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module rci_isqrt import rci_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SQ_IN_W-1:0]  rad,
  output logic [SQ_OUT_W-1:0] root
);

  logic [SQ_IN_W-1:0]  rem_r [SQ_LAT];
  logic [SQ_OUT_W-1:0] q_r   [SQ_LAT];

  // Each stage tries to set one root bit, highest first.
  for (genvar k = 0; k < SQ_LAT; k++) begin : g_stage
    localparam int B = SQ_LAT - 1 - k;
    logic [SQ_IN_W-1:0]  rem_in;
    logic [SQ_IN_W-1:0]  trial;
    logic [SQ_OUT_W-1:0] q_in;

    if (k == 0) begin : g_first
      assign rem_in = rad;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
    end

    // (q + 2^B)^2 - q^2 = (2q + 2^B) * 2^B
    assign trial = (SQ_IN_W'(q_in) << (B + 1)) | (SQ_IN_W'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          q_r[k]   <= q_in | (SQ_OUT_W'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign root = q_r[SQ_LAT-1];

endmodule

@@ sv/rci_div.sv @@
// Pipelined restoring divider giving min(num * 2^15 / den, 32767) in two parts.
module rci_div import rci_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [N_W-1:0]      num,
  input  logic [SQ_OUT_W-1:0] den,
  output logic [DQ_W-1:0]     quo,
  output logic                sat
);

  logic [REM_W-1:0]    rem_r [DIV_LAT];
  logic [DQ_W-1:0]     q_r   [DIV_LAT];
  logic [SQ_OUT_W-1:0] den_r [DIV_LAT];
  logic                sat_r [DIV_LAT];

  // One quotient bit per stage, highest first.
  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    localparam int B = DIV_LAT - 1 - k;
    logic [REM_W-1:0]    rem_in;
    logic [REM_W-1:0]    rem2;
    logic [DQ_W-1:0]     q_in;
    logic [SQ_OUT_W-1:0] den_in;
    logic                sat_in;

    if (k == 0) begin : g_first
      assign rem_in = REM_W'(num);
      assign q_in   = '0;
      assign den_in = den;
      // A quotient of 2^15 or more saturates.
      assign sat_in = SQ_OUT_W'(num) >= den;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign sat_in = sat_r[k-1];
    end

    assign rem2 = rem_in << 1;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        sat_r[k] <= sat_in;
        if (rem2 >= REM_W'(den_in)) begin
          rem_r[k] <= rem2 - REM_W'(den_in);
          q_r[k]   <= q_in | (DQ_W'(1) << B);
        end else begin
          rem_r[k] <= rem2;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];
  assign sat = sat_r[DIV_LAT-1];

endmodule

@@ sv/ray_circle_intersection_top.sv @@
// Top level of the ray-circle intersection pipeline.
//
// Rays arrive on in_if, one transfer per item: origin and unit direction,
// circle center, radius and shape offset. Each ray gives exactly one result
// on out_if: hit flag, entry and exit distances, and unit normals at both
// points. A miss gives all fields zero.
//
// Throughput is one item per cycle while out_if is not blocked. From the input
// transfer to the result being shown there are 6 stages for the offset vector,
// projection and discriminant, 31 stages of the first square root (one root
// bit each), 8 stages for distances and normal vectors, 31 stages of the
// second square root for the normal length, 15 divider stages (one quotient
// bit each) and the output register.
//
// The whole pipeline moves as one: when a result waits in the output
// register and out_if.ready is low, every stage holds and in_if.ready drops.
// Nothing is lost or repeated. Reset clears all valid bits; the block can take
// a ray as soon as reset is released.
module ray_circle_intersection_top import rci_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rci_in_if.sink    in_if,
  rci_out_if.source out_if
);

  logic en;
  logic out_valid_r;

  // The pipeline advances unless a finished result is blocked.
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Stage 1: vector from origin to the shifted center.
  logic                    v1_r;
  logic signed [OC_W-1:0]  ocx1_r, ocy1_r;
  logic signed [DIR_W-1:0] dx1_r, dy1_r;
  logic [R_W-1:0]          r1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ocx1_r <= OC_W'(in_if.center_x) + OC_W'(in_if.offset_x) - OC_W'(in_if.origin_x);
      ocy1_r <= OC_W'(in_if.center_y) + OC_W'(in_if.offset_y) - OC_W'(in_if.origin_y);
      dx1_r  <= in_if.dir_x;
      dy1_r  <= in_if.dir_y;
      r1_r   <= in_if.circle_radius;
    end
  end

  // Stage 2: the four direction products.
  logic                    v2_r;
  logic signed [PR_W-1:0]  pxx2_r, pyy2_r, pxy2_r, pyx2_r;
  logic signed [OC_W-1:0]  ocx2_r, ocy2_r;
  logic signed [DIR_W-1:0] dx2_r, dy2_r;
  logic [R_W-1:0]          r2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pxx2_r <= PR_W'(dx1_r) * PR_W'(ocx1_r);
      pyy2_r <= PR_W'(dy1_r) * PR_W'(ocy1_r);
      pxy2_r <= PR_W'(dx1_r) * PR_W'(ocy1_r);
      pyx2_r <= PR_W'(dy1_r) * PR_W'(ocx1_r);
      ocx2_r <= ocx1_r;
      ocy2_r <= ocy1_r;
      dx2_r  <= dx1_r;
      dy2_r  <= dy1_r;
      r2_r   <= r1_r;
    end
  end

  // Stage 3: rounded projection and perpendicular distance.
  logic                    v3_r;
  logic signed [PS_W-1:0]  proj_sum, perp_sum;
  logic signed [PJ_W-1:0]  proj3_r, perp3_r;
  logic signed [OC_W-1:0]  ocx3_r, ocy3_r;
  logic signed [DIR_W-1:0] dx3_r, dy3_r;
  logic [R_W-1:0]          r3_r;

  assign proj_sum = PS_W'(pxx2_r) + PS_W'(pyy2_r) + PS_W'(RND_HALF);
  assign perp_sum = PS_W'(pxy2_r) - PS_W'(pyx2_r) + PS_W'(RND_HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      proj3_r <= PJ_W'(proj_sum >>> FRAC_SH);
      perp3_r <= PJ_W'(perp_sum >>> FRAC_SH);
      ocx3_r  <= ocx2_r;
      ocy3_r  <= ocy2_r;
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
      r3_r    <= r2_r;
    end
  end

  // Stage 4: the two early miss tests.
  logic                    v4_r;
  logic signed [PJ_W-1:0]  neg_r3;
  logic [PJ_W-1:0]         ap3;
  logic                    miss4_r;
  logic signed [PJ_W-1:0]  proj4_r;
  logic [R_W-1:0]          ap4_r;
  logic signed [OC_W-1:0]  ocx4_r, ocy4_r;
  logic signed [DIR_W-1:0] dx4_r, dy4_r;
  logic [R_W-1:0]          r4_r;

  assign neg_r3 = -$signed({{(PJ_W - R_W){1'b0}}, r3_r});
  assign ap3    = perp3_r[PJ_W-1] ? PJ_W'(-perp3_r) : PJ_W'(perp3_r);

  always_ff @(posedge clk) begin
    if (en) begin
      miss4_r <= (proj3_r < neg_r3) || (ap3 > PJ_W'(r3_r));
      proj4_r <= proj3_r;
      ap4_r   <= ap3[R_W-1:0];
      ocx4_r  <= ocx3_r;
      ocy4_r  <= ocy3_r;
      dx4_r   <= dx3_r;
      dy4_r   <= dy3_r;
      r4_r    <= r3_r;
    end
  end

  // Stage 5: squares of radius and perpendicular distance.
  logic                 v5_r;
  logic [SQ_IN_W-1:0]   rr5_r, aa5_r;
  side1_t               sd5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rr5_r <= SQ_IN_W'(r4_r) * SQ_IN_W'(r4_r);
      aa5_r <= SQ_IN_W'(ap4_r) * SQ_IN_W'(ap4_r);
      sd5_r <= '{miss: miss4_r, proj: proj4_r, ocx: ocx4_r, ocy: ocy4_r,
                 dx: dx4_r, dy: dy4_r};
    end
  end

  // Stage 6: discriminant. It is only meaningful when no miss was found.
  logic               v6_r;
  logic [SQ_IN_W-1:0] d6_r;
  side1_t             sd6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d6_r  <= rr5_r - aa5_r;
      sd6_r <= sd5_r;
    end
  end

  // Half chord length, with the item's data carried alongside.
  logic [SQ_OUT_W-1:0] s_root;
  logic [SQ_LAT-1:0]   vs1_r;
  side1_t              s1l_r [SQ_LAT];

  rci_isqrt u_sqrt_chord (
    .clk  (clk),
    .en   (en),
    .rad  (d6_r),
    .root (s_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      s1l_r[0] <= sd6_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        s1l_r[i] <= s1l_r[i-1];
      end
    end
  end

  // Stage 7: entry and exit distances.
  side1_t                  sd_q;
  logic signed [T_W-1:0]   t1, t2;
  logic                    v7_r;
  logic                    hit7_r;
  logic signed [T_W-1:0]   t1c7_r, t2_7_r;
  logic signed [OC_W-1:0]  ocx7_r, ocy7_r;
  logic signed [DIR_W-1:0] dx7_r, dy7_r;

  assign sd_q = s1l_r[SQ_LAT-1];
  assign t1   = T_W'(sd_q.proj) - T_W'($signed({1'b0, s_root}));
  assign t2   = T_W'(sd_q.proj) + T_W'($signed({1'b0, s_root}));

  always_ff @(posedge clk) begin
    if (en) begin
      hit7_r <= !sd_q.miss && !t2[T_W-1];
      t1c7_r <= t1[T_W-1] ? '0 : t1;
      t2_7_r <= t2;
      ocx7_r <= sd_q.ocx;
      ocy7_r <= sd_q.ocy;
      dx7_r  <= sd_q.dx;
      dy7_r  <= sd_q.dy;
    end
  end

  // Stage 8: direction times distance for both points; saturated distances.
  logic                   v8_r;
  logic signed [TP_W-1:0] px8_r [2];
  logic signed [TP_W-1:0] py8_r [2];
  logic signed [OC_W-1:0] ocx8_r, ocy8_r;
  res_t                   res8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px8_r[0] <= TP_W'(dx7_r) * TP_W'(t1c7_r);
      py8_r[0] <= TP_W'(dy7_r) * TP_W'(t1c7_r);
      px8_r[1] <= TP_W'(dx7_r) * TP_W'(t2_7_r);
      py8_r[1] <= TP_W'(dy7_r) * TP_W'(t2_7_r);
      ocx8_r   <= ocx7_r;
      ocy8_r   <= ocy7_r;
      res8_r   <= '{hit: hit7_r, ent_zero: (t1c7_r == '0),
                    ent_d: sat_dist(t1c7_r), ext_d: sat_dist(t2_7_r)};
    end
  end

  // Stage 9: normal vectors with 31 fraction bits.
  logic                  v9_r;
  logic signed [V_W-1:0] vx9_r [2];
  logic signed [V_W-1:0] vy9_r [2];
  res_t                  res9_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        vx9_r[k] <= V_W'(px8_r[k]) - (V_W'(ocx8_r) <<< FRAC_SH);
        vy9_r[k] <= V_W'(py8_r[k]) - (V_W'(ocy8_r) <<< FRAC_SH);
      end
      res9_r <= res8_r;
    end
  end

  // Stage 10: magnitudes and signs.
  logic             v10_r;
  logic [M_W-1:0]   ax10_r [2];
  logic [M_W-1:0]   ay10_r [2];
  logic [1:0]       sx10_r, sy10_r, zr10_r;
  res_t             res10_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        ax10_r[k] <= vx9_r[k][V_W-1] ? M_W'(-vx9_r[k]) : M_W'(vx9_r[k]);
        ay10_r[k] <= vy9_r[k][V_W-1] ? M_W'(-vy9_r[k]) : M_W'(vy9_r[k]);
        sx10_r[k] <= vx9_r[k][V_W-1];
        sy10_r[k] <= vy9_r[k][V_W-1];
        zr10_r[k] <= (vx9_r[k] == '0) && (vy9_r[k] == '0);
      end
      res10_r <= res9_r;
    end
  end

  // Stage 11: shift that brings both components below 2^30.
  logic            v11_r;
  logic [M_W-1:0]  am10 [2];
  logic [SH_W-1:0] sh10 [2];
  logic [M_W-1:0]  ax11_r [2];
  logic [M_W-1:0]  ay11_r [2];
  logic [SH_W-1:0] sh11_r [2];
  logic [1:0]      sx11_r, sy11_r, zr11_r;
  res_t            res11_r;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      am10[k] = ax10_r[k] | ay10_r[k];
      sh10[k] = '0;
      for (int i = 0; i < SH_N; i++) begin
        if (|(am10[k] >> (N_W + i))) begin
          sh10[k] = SH_W'(i + 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax11_r  <= ax10_r;
      ay11_r  <= ay10_r;
      sh11_r  <= sh10;
      sx11_r  <= sx10_r;
      sy11_r  <= sy10_r;
      zr11_r  <= zr10_r;
      res11_r <= res10_r;
    end
  end

  // Stage 12: normalized components.
  logic           v12_r;
  logic [N_W-1:0] nx12_r [2];
  logic [N_W-1:0] ny12_r [2];
  logic [1:0]     sx12_r, sy12_r, zr12_r;
  res_t           res12_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        nx12_r[k] <= N_W'(ax11_r[k] >> sh11_r[k]);
        ny12_r[k] <= N_W'(ay11_r[k] >> sh11_r[k]);
      end
      sx12_r  <= sx11_r;
      sy12_r  <= sy11_r;
      zr12_r  <= zr11_r;
      res12_r <= res11_r;
    end
  end

  // Stage 13: squares of the normalized components.
  logic               v13_r;
  logic [2*N_W-1:0]   qx13_r [2];
  logic [2*N_W-1:0]   qy13_r [2];
  logic [N_W-1:0]     nx13_r [2];
  logic [N_W-1:0]     ny13_r [2];
  logic [1:0]         sx13_r, sy13_r, zr13_r;
  res_t               res13_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        qx13_r[k] <= (2*N_W)'(nx12_r[k]) * (2*N_W)'(nx12_r[k]);
        qy13_r[k] <= (2*N_W)'(ny12_r[k]) * (2*N_W)'(ny12_r[k]);
      end
      nx13_r  <= nx12_r;
      ny13_r  <= ny12_r;
      sx13_r  <= sx12_r;
      sy13_r  <= sy12_r;
      zr13_r  <= zr12_r;
      res13_r <= res12_r;
    end
  end

  // Stage 14: squared length.
  logic               v14_r;
  logic [SQ_IN_W-1:0] ls14_r [2];
  sidea_t             sa14_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        ls14_r[k]    <= SQ_IN_W'(qx13_r[k]) + SQ_IN_W'(qy13_r[k]);
        sa14_r.nx[k] <= nx13_r[k];
        sa14_r.ny[k] <= ny13_r[k];
      end
      sa14_r.sx  <= sx13_r;
      sa14_r.sy  <= sy13_r;
      sa14_r.zr  <= zr13_r;
      sa14_r.res <= res13_r;
    end
  end

  // Normal lengths at entry and exit.
  logic [SQ_OUT_W-1:0] len_q [2];
  logic [SQ_LAT-1:0]   vs2_r;
  sidea_t              sal_r [SQ_LAT];

  for (genvar k = 0; k < 2; k++) begin : g_len
    rci_isqrt u_sqrt_len (
      .clk  (clk),
      .en   (en),
      .rad  (ls14_r[k]),
      .root (len_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sal_r[0] <= sa14_r;
      for (int i = 1; i < SQ_LAT; i++) begin
        sal_r[i] <= sal_r[i-1];
      end
    end
  end

  // Component over length for all four normal components.
  sidea_t          sa_q;
  logic [DQ_W-1:0] qx_q [2];
  logic [DQ_W-1:0] qy_q [2];
  logic            sx_q [2];
  logic            sy_q [2];
  logic [DIV_LAT-1:0] vd_r;
  sideb_t          sbl_r [DIV_LAT];

  assign sa_q = sal_r[SQ_LAT-1];

  for (genvar k = 0; k < 2; k++) begin : g_div
    rci_div u_div_x (
      .clk (clk),
      .en  (en),
      .num (sa_q.nx[k]),
      .den (len_q[k]),
      .quo (qx_q[k]),
      .sat (sx_q[k])
    );
    rci_div u_div_y (
      .clk (clk),
      .en  (en),
      .num (sa_q.ny[k]),
      .den (len_q[k]),
      .quo (qy_q[k]),
      .sat (sy_q[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbl_r[0] <= '{res: sa_q.res, sx: sa_q.sx, sy: sa_q.sy, zr: sa_q.zr};
      for (int i = 1; i < DIV_LAT; i++) begin
        sbl_r[i] <= sbl_r[i-1];
      end
    end
  end

  // Output register: distances and normals, all zero on a miss.
  sideb_t                  sb_q;
  logic                    ent_off;
  logic                    hit_r;
  logic [DST_W-1:0]        ent_d_r, ext_d_r;
  logic signed [NRM_W-1:0] enx_r, eny_r, xnx_r, xny_r;

  assign sb_q    = sbl_r[DIV_LAT-1];
  assign ent_off = !sb_q.res.hit || sb_q.res.ent_zero;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r   <= sb_q.res.hit;
      ent_d_r <= sb_q.res.hit ? sb_q.res.ent_d : '0;
      ext_d_r <= sb_q.res.hit ? sb_q.res.ext_d : '0;
      enx_r   <= nrm_fix(qx_q[0], sx_q[0], sb_q.sx[0], sb_q.zr[0] || ent_off);
      eny_r   <= nrm_fix(qy_q[0], sy_q[0], sb_q.sy[0], sb_q.zr[0] || ent_off);
      xnx_r   <= nrm_fix(qx_q[1], sx_q[1], sb_q.sx[1], sb_q.zr[1] || !sb_q.res.hit);
      xny_r   <= nrm_fix(qy_q[1], sy_q[1], sb_q.sy[1], sb_q.zr[1] || !sb_q.res.hit);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      vs1_r       <= '0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      v9_r        <= 1'b0;
      v10_r       <= 1'b0;
      v11_r       <= 1'b0;
      v12_r       <= 1'b0;
      v13_r       <= 1'b0;
      v14_r       <= 1'b0;
      vs2_r       <= '0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_if.valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      vs1_r       <= {vs1_r[SQ_LAT-2:0], v6_r};
      v7_r        <= vs1_r[SQ_LAT-1];
      v8_r        <= v7_r;
      v9_r        <= v8_r;
      v10_r       <= v9_r;
      v11_r       <= v10_r;
      v12_r       <= v11_r;
      v13_r       <= v12_r;
      v14_r       <= v13_r;
      vs2_r       <= {vs2_r[SQ_LAT-2:0], v14_r};
      vd_r        <= {vd_r[DIV_LAT-2:0], vs2_r[SQ_LAT-1]};
      out_valid_r <= vd_r[DIV_LAT-1];
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.hit            = hit_r;
  assign out_if.enter_distance = ent_d_r;
  assign out_if.exit_distance  = ext_d_r;
  assign out_if.enter_normal_x = enx_r;
  assign out_if.enter_normal_y = eny_r;
  assign out_if.exit_normal_x  = xnx_r;
  assign out_if.exit_normal_y  = xny_r;

  // Entry never lies beyond exit.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r |-> ent_d_r <= ext_d_r)
    else $error("entry distance beyond exit distance");

  // A miss carries no distances or normals.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !hit_r |-> ent_d_r == '0 && ext_d_r == '0 && enx_r == '0 &&
                             eny_r == '0 && xnx_r == '0 && xny_r == '0)
    else $error("miss result carries nonzero fields");

  // An entry at distance zero has no entry normal.
  a_ent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && hit_r && ent_d_r == '0 |-> enx_r == '0 && eny_r == '0)
    else $error("entry normal set at zero entry distance");

  // A blocked result freezes the whole pipeline, so no ray is taken.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_if.ready |=> $stable(v1_r) && $stable(vd_r))
    else $error("pipeline moved while the output was blocked");

endmodule

@@ tb/rci_check.sv @@
`timescale 1ns / 1ps
// Result checker for the ray-circle intersection block: predicts each result and compares it.
module rci_check import rci_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  rci_in_if.sink    in_mon,
  rci_out_if.sink   out_mon,
  output int        err_count,
  output int        pending
);

  typedef struct packed {
    logic                    hit;
    logic [DST_W-1:0]        ent_d;
    logic [DST_W-1:0]        ext_d;
    logic signed [NRM_W-1:0] enx;
    logic signed [NRM_W-1:0] eny;
    logic signed [NRM_W-1:0] xnx;
    logic signed [NRM_W-1:0] xny;
  } hit_rec_t;

  hit_rec_t expected_hits[$];

  assign pending = expected_hits.size();

  // Integer square root, floor.
  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a vector to unit length in Q1.15.
  function automatic void unit_normal(input longint vx, input longint vy,
                                      output logic signed [NRM_W-1:0] nx,
                                      output logic signed [NRM_W-1:0] ny);
    logic [63:0] ax, ay, len, qx, qy;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    len = root_floor(ax * ax + ay * ay);
    if (len == 0) begin
      nx = '0;
      ny = '0;
      return;
    end
    qx = (ax << 15) / len;
    qy = (ay << 15) / len;
    if (qx > 32767) qx = 32767;
    if (qy > 32767) qy = 32767;
    nx = vx < 0 ? -NRM_W'(qx) : NRM_W'(qx);
    ny = vy < 0 ? -NRM_W'(qy) : NRM_W'(qy);
  endfunction

  function automatic logic [DST_W-1:0] clamp_dist(longint t);
    if (t < 0) return '0;
    if (t > 64'sh0FFFF_FFFF) return '1;
    return t[DST_W-1:0];
  endfunction

  // Solve one ray against one circle.
  function automatic hit_rec_t solve_ray(longint ox, longint oy, longint dx, longint dy,
                                         longint cx, longint cy, longint r,
                                         longint px, longint py);
    hit_rec_t res;
    longint ocx, ocy, proj, perp, ap, s, t1, t2;
    res = '0;
    ocx = cx + px - ox;
    ocy = cy + py - oy;
    proj = (dx * ocx + dy * ocy + 16384) >>> 15;
    perp = (dx * ocy - dy * ocx + 16384) >>> 15;
    if (proj < -r) return res;
    ap = perp < 0 ? -perp : perp;
    if (ap > r) return res;
    s = longint'(root_floor(64'(r * r - ap * ap)));
    t1 = proj - s;
    t2 = proj + s;
    if (t2 < 0) return res;
    if (t1 < 0) t1 = 0;
    if (t1 != 0) unit_normal(dx * t1 - ocx * 32768, dy * t1 - ocy * 32768, res.enx, res.eny);
    unit_normal(dx * t2 - ocx * 32768, dy * t2 - ocy * 32768, res.xnx, res.xny);
    res.hit = 1'b1;
    res.ent_d = clamp_dist(t1);
    res.ext_d = clamp_dist(t2);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb: mismatch on %s: got %0h, expected %0h", what, got, want);
    err_count++;
  endtask

  initial err_count = 0;

  // Predict on every input transfer.
  always @(posedge clk) begin
    if (rst_n && in_mon.valid && in_mon.ready) begin
      expected_hits.push_back(solve_ray(in_mon.origin_x, in_mon.origin_y, in_mon.dir_x,
        in_mon.dir_y, in_mon.center_x, in_mon.center_y, longint'(in_mon.circle_radius),
        in_mon.offset_x, in_mon.offset_y));
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    hit_rec_t want;
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_mon.hit !== want.hit) report_mismatch("hit", out_mon.hit, want.hit);
        if (out_mon.enter_distance !== want.ent_d)
          report_mismatch("enter_distance", out_mon.enter_distance, want.ent_d);
        if (out_mon.exit_distance !== want.ext_d)
          report_mismatch("exit_distance", out_mon.exit_distance, want.ext_d);
        if (out_mon.enter_normal_x !== want.enx)
          report_mismatch("enter_normal_x", out_mon.enter_normal_x, want.enx);
        if (out_mon.enter_normal_y !== want.eny)
          report_mismatch("enter_normal_y", out_mon.enter_normal_y, want.eny);
        if (out_mon.exit_normal_x !== want.xnx)
          report_mismatch("exit_normal_x", out_mon.exit_normal_x, want.xnx);
        if (out_mon.exit_normal_y !== want.xny)
          report_mismatch("exit_normal_y", out_mon.exit_normal_y, want.xny);
      end
    end
  end

endmodule

@@ tb/tb_ray_circle_intersection_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the ray-circle intersection block: stimulus, idling and verdict.
module tb_ray_circle_intersection_top;

  localparam int PIPE_LAT   = 92;
  localparam int RAND_ITEMS = 680;
  localparam int CALM_ITEMS = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   err_count;
  int   pending;
  bit   calm = 1'b0;

  rci_in_if  in_if ();
  rci_out_if out_if ();

  ray_circle_intersection_top u_top (.clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if));
  rci_check u_check (.clk(clk), .rst_n(rst_n), .in_mon(in_if), .out_mon(out_if),
                     .err_count(err_count), .pending(pending));

  always #5 clk = ~clk;

  // Receiver stalls in random bursts, none during the calm tail.
  initial begin
    int n;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (1) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 6);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(1, 12);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Send one ray; optionally idle in a random burst first.
  task automatic send_ray(logic signed [31:0] ox, logic signed [31:0] oy,
                          logic signed [15:0] dx, logic signed [15:0] dy,
                          logic signed [31:0] cx, logic signed [31:0] cy,
                          logic [30:0] r, logic signed [31:0] px, logic signed [31:0] py);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.origin_x <= ox;
    in_if.origin_y <= oy;
    in_if.dir_x <= dx;
    in_if.dir_y <= dy;
    in_if.center_x <= cx;
    in_if.center_y <= cy;
    in_if.circle_radius <= r;
    in_if.offset_x <= px;
    in_if.offset_y <= py;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  // Random unit direction in Q1.15 from a random angle; one ray in ten gets raw random components.
  task automatic send_random_ray(bit wide);
    real ang;
    logic signed [15:0] dx, dy;
    logic signed [31:0] ox, oy, cx, cy, px, py;
    logic [30:0] r;
    ang = $urandom_range(0, 62831) / 10000.0;
    dx = 16'($rtoi($cos(ang) * 32767.0));
    dy = 16'($rtoi($sin(ang) * 32767.0));
    if ($urandom_range(0, 9) == 0) begin
      dx = 16'($urandom);
      dy = 16'($urandom);
    end
    if (wide) begin
      ox = $urandom; oy = $urandom; cx = $urandom; cy = $urandom;
      px = $urandom; py = $urandom; r = 31'($urandom);
    end else begin
      // Small scenes so that hits, inside origins and misses all occur.
      ox = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      oy = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      cx = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      cy = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      px = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      py = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      r = 31'($urandom_range(0, 32'h0030_0000));
    end
    send_ray(ox, oy, dx, dy, cx, cy, r, px, py);
  endtask

  initial begin
    in_if.valid <= 1'b0;
    in_if.origin_x <= '0;
    in_if.origin_y <= '0;
    in_if.dir_x <= '0;
    in_if.dir_y <= '0;
    in_if.center_x <= '0;
    in_if.center_y <= '0;
    in_if.circle_radius <= '0;
    in_if.offset_x <= '0;
    in_if.offset_y <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: hit, inside origin, tangent, behind, miss, zero radius, edge, -x, -y, diagonal.
    send_ray(0, 0, 16'sh7FFF, 0, 32'sh000A_0000, 0, 31'h0002_0000, 0, 0);
    send_ray(0, 0, 16'sh7FFF, 0, 32'sh0001_0000, 0, 31'h0004_0000, 0, 0);
    send_ray(0, 0, 0, 16'sh7FFF, 32'sh0002_0000, 32'sh0005_0000, 31'h0002_0000, 0, 0);
    send_ray(0, 0, 16'sh7FFF, 0, -32'sh000A_0000, 0, 31'h0002_0000, 0, 0);
    send_ray(0, 0, 16'sh7FFF, 0, 32'sh000A_0000, 32'sh0009_0000, 31'h0002_0000, 0, 0);
    send_ray(0, 0, 16'sh7FFF, 0, 0, 0, 31'd0, 0, 0);
    send_ray(0, 0, 16'sh7FFF, 0, 32'sh0002_0000, 0, 31'h0002_0000, 0, 0);
    send_ray(0, 0, -16'sh8000, 0, -32'sh0005_0000, 0, 31'h0001_0000, 0, 0);
    send_ray(0, 0, 0, -16'sh8000, 0, -32'sh0005_0000, 31'h0001_0000, 0, 0);
    send_ray(0, 0, 16'sh5A82, 16'sh5A82, 32'sh0003_0000, 0, 31'h0001_0000,
             0, 32'sh0003_0000);
    // Extremes: far circles, saturating distances, full-scale fields.
    send_ray(32'sh8000_0000, 32'sh8000_0000, 16'sh5A82, 16'sh5A82, 32'sh7FFF_FFFF,
             32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, -16'sh8000, -16'sh8000, 32'sh8000_0000,
             32'sh8000_0000, 31'h7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    send_ray(32'sh8000_0000, 0, 16'sh7FFF, 0, 32'sh7FFF_FFFF, 0, 31'h0001_0000,
             32'sh7FFF_FFFF, 0);
    send_ray(0, 0, 16'sh7FFF, 16'sh7FFF, 0, 0, 31'h7FFF_FFFF, 0, 0);
    send_ray(-1, -1, 16'shFFFF, 16'shFFFF, 1, 1, 31'd1, -1, -1);
    send_ray(0, 0, 0, 0, 32'sh0001_0000, 0, 31'h0002_0000, 0, 0);

    // Let the pipeline drain completely once.
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);

    for (int i = 0; i < RAND_ITEMS; i++) send_random_ray($urandom_range(0, 7) == 0);
    calm = 1'b1;
    for (int i = 0; i < CALM_ITEMS; i++) send_random_ray(1'b0);
    in_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
